// ===== design/wwbf_pkg.sv =====
// Shared types, constants and helper functions for the word wrap break finder.
// No dependencies; every other design file imports this package.
package wwbf_pkg;

    // Widths of the running state and of the item fields
    localparam int INDEX_BITS    = 16;
    localparam int POS_BITS      = 16;
    localparam int WIDTH_BITS    = 16;
    localparam int CHAR_BITS     = 8;
    localparam int GLYPH_BITS    = 8;

    // Configuration port
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // Result queue
    localparam int QDEPTH        = 4;
    localparam int QAW           = $clog2(QDEPTH);
    localparam int QCW           = $clog2(QDEPTH + 1);

    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [POS_BITS-1:0]   t_pos;
    typedef logic [WIDTH_BITS-1:0] t_width;
    typedef logic [CHAR_BITS-1:0]  t_char;
    typedef logic [GLYPH_BITS-1:0] t_glyph;

    // Command codes
    localparam logic CMD_FINISH = 1'b1;

    // Register indexes (address bit 2)
    localparam logic REG_BOX_WIDTH  = 1'b0;
    localparam logic REG_FONT_READY = 1'b1;

    localparam t_width BOX_WIDTH_RST  = t_width'(256);
    localparam logic   FONT_READY_RST = 1'b1;

    localparam t_char NL_CODE = 8'h0A;

    // Configuration seen by the datapath
    typedef struct packed {
        t_width box_width;
        logic   font_ready;
    } t_cfg;

    // One result item
    typedef struct packed {
        t_pos line_start;
        logic is_end;
        logic last;
    } t_res;

    // Results produced by one accepted item (0, 1 or 2)
    typedef struct packed {
        logic [1:0] cnt;
        t_res       first;
        t_res       second;
    } t_push;

    // Space and punctuation where a line may break
    function automatic logic is_break_char(input t_char c);
        logic hit;
        case (c) inside
            8'h20, 8'h2C, 8'h2E, 8'h2D, 8'h3A, 8'h3B,
            8'h3F, 8'h21, 8'h2B, 8'h3D, 8'h2F, 8'h5C: hit = 1'b1;
            default:                                  hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Width plus glyph plus one pixel of spacing, saturating
    function automatic t_width sat_add(input t_width a, input t_glyph g);
        logic [WIDTH_BITS:0] s;
        s = (WIDTH_BITS+1)'(a) + (WIDTH_BITS+1)'(g) + (WIDTH_BITS+1)'(1);
        return s[WIDTH_BITS] ? '1 : s[WIDTH_BITS-1:0];
    endfunction

    // Character index as it appears on the result port
    function automatic t_pos idx_to_pos(input t_index i);
        return t_pos'(i);
    endfunction

endpackage

// ===== design/wwbf_cfg.sv =====
// APB-style configuration registers: box width and font ready flag.
// Depends on wwbf_pkg.
module wwbf_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wwbf_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [wwbf_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [wwbf_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready,
    output wwbf_pkg::t_cfg                     o_cfg
);
    import wwbf_pkg::*;

    t_width r_box_width;
    logic   r_font_ready;
    logic   reg_idx;
    logic   wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_BITS-1];
    assign wr_en   = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_width  <= BOX_WIDTH_RST;
            r_font_ready <= FONT_READY_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BOX_WIDTH:  r_box_width  <= pwdata[WIDTH_BITS-1:0];
                REG_FONT_READY: r_font_ready <= pwdata[0];
                default:        r_box_width  <= r_box_width;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_BOX_WIDTH:  prdata = CFG_DATA_BITS'(r_box_width);
            REG_FONT_READY: prdata = CFG_DATA_BITS'(r_font_ready);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.box_width  = r_box_width;
    assign o_cfg.font_ready = r_font_ready;

endmodule

// ===== design/wwbf_core.sv =====
// Running text state and the combinational break decision for each accepted item.
// Depends on wwbf_pkg; results leave through a t_push to the result queue.
module wwbf_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wwbf_pkg::t_cfg               i_cfg,
    input  logic                         i_accept,
    input  logic                         i_cmd,
    input  logic [wwbf_pkg::CHAR_BITS-1:0]  i_char_code,
    input  logic                         i_glyph_supported,
    input  logic [wwbf_pkg::GLYPH_BITS-1:0] i_glyph_width,
    output wwbf_pkg::t_push              o_push
);
    import wwbf_pkg::*;

    t_index r_char_index,   n_char_index;
    t_width r_line_width,   n_line_width;
    t_width r_word_width,   n_word_width;
    t_index r_break_index,  n_break_index;
    t_index r_last_emitted, n_last_emitted;
    logic   r_text_started, n_text_started;

    logic   emit0;
    logic   main_v;
    t_pos   main_pos;
    logic   main_end;
    t_index ci_inc;
    t_width lw_add;
    t_width ww_add;

    assign ci_inc = (r_char_index != '1) ? r_char_index + t_index'(1) : r_char_index;
    assign lw_add = sat_add(r_line_width, i_glyph_width);
    assign ww_add = sat_add(r_word_width, i_glyph_width);
    assign emit0  = i_cfg.font_ready & ~r_text_started;

    // Next state and the main result of this item
    always_comb begin
        n_char_index   = r_char_index;
        n_line_width   = r_line_width;
        n_word_width   = r_word_width;
        n_break_index  = r_break_index;
        n_last_emitted = r_last_emitted;
        n_text_started = r_text_started;
        main_v         = 1'b0;
        main_pos       = '0;
        main_end       = 1'b0;

        if (!i_cfg.font_ready) begin
            // font invalid: finish still closes the text, nothing is emitted
            if (i_cmd == CMD_FINISH) begin
                n_char_index   = '0;
                n_line_width   = '0;
                n_word_width   = '0;
                n_break_index  = '0;
                n_last_emitted = '0;
                n_text_started = 1'b0;
            end
        end else begin
            n_text_started = 1'b1;
            if (emit0) begin
                n_last_emitted = '0;
            end
            if (i_cmd == CMD_FINISH) begin
                main_v         = 1'b1;
                main_pos       = idx_to_pos(r_char_index);
                main_end       = 1'b1;
                n_char_index   = '0;
                n_line_width   = '0;
                n_word_width   = '0;
                n_break_index  = '0;
                n_last_emitted = '0;
                n_text_started = 1'b0;
            end else begin
                n_char_index = ci_inc;
                if (i_glyph_supported) begin
                    n_line_width = lw_add;
                    n_word_width = ww_add;
                end
                if (i_char_code == NL_CODE) begin
                    // forced line start right after the newline
                    main_v         = 1'b1;
                    main_pos       = idx_to_pos(ci_inc);
                    n_last_emitted = ci_inc;
                    n_line_width   = '0;
                    n_word_width   = '0;
                    n_break_index  = ci_inc;
                end else if (is_break_char(i_char_code)) begin
                    n_break_index = ci_inc;
                    n_word_width  = '0;
                end
                // overflow: break at the last break point, carry the word over
                if (n_line_width >= i_cfg.box_width) begin
                    if (n_break_index != n_last_emitted) begin
                        main_v         = 1'b1;
                        main_pos       = idx_to_pos(n_break_index);
                        n_last_emitted = n_break_index;
                    end
                    n_line_width = n_word_width;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_index   <= '0;
            r_line_width   <= '0;
            r_word_width   <= '0;
            r_break_index  <= '0;
            r_last_emitted <= '0;
            r_text_started <= 1'b0;
        end else if (i_accept) begin
            r_char_index   <= n_char_index;
            r_line_width   <= n_line_width;
            r_word_width   <= n_word_width;
            r_break_index  <= n_break_index;
            r_last_emitted <= n_last_emitted;
            r_text_started <= n_text_started;
        end
    end

    // Pack results: leading zero position first, then the main result
    always_comb begin
        o_push.cnt = i_accept ? (2'(emit0) + 2'(main_v)) : 2'd0;
        if (emit0) begin
            o_push.first.line_start = '0;
            o_push.first.is_end     = 1'b0;
            o_push.first.last       = ~main_v;
        end else begin
            o_push.first.line_start = main_pos;
            o_push.first.is_end     = main_end;
            o_push.first.last       = 1'b1;
        end
        o_push.second.line_start = main_pos;
        o_push.second.is_end     = main_end;
        o_push.second.last       = 1'b1;
    end

`ifndef NO_ASSERTIONS
    a_font_off_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cfg.font_ready |-> o_push.cnt == 2'd0)
        else $error("results produced while font is not ready");

    a_finish_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_cmd == CMD_FINISH) |=> !r_text_started)
        else $error("text still open after a finish");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.cnt == 2'd1 |-> o_push.first.last)
        else $error("lone result not marked last of run");
`endif

endmodule

// ===== design/wwbf_outq.sv =====
// Small result queue: takes up to two results per cycle, delivers one.
// Depends on wwbf_pkg.
module wwbf_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wwbf_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_room,
    output wwbf_pkg::t_res  o_head
);
    import wwbf_pkg::*;

    t_res           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QCW-1:0] r_count;
    logic [QAW-1:0] wr_nxt;

    assign wr_nxt  = r_wr + QAW'(1);
    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= QCW'(QDEPTH - 2));
    assign o_head  = r_mem[r_rd];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_nxt] <= i_push.second;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QAW'(i_push.cnt);
            r_rd    <= r_rd + QAW'(i_pop);
            r_count <= r_count + QCW'(i_push.cnt) - QCW'(i_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCW'(QDEPTH))
        else $error("result queue count beyond depth");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.cnt != 2'd0 |-> o_room)
        else $error("results pushed without room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && i_push.cnt == 2'd0) |=> r_count == $past(r_count) - QCW'(1))
        else $error("pop did not reduce queue count");
`endif

endmodule

// ===== design/word_wrap_break_finder.sv =====
// Top level of the word wrap break finder: configuration, break logic, result queue.
// Depends on wwbf_pkg, wwbf_cfg, wwbf_core and wwbf_outq.
//
// Takes one text character (or finish command) per cycle and returns the character
// indices where display lines start. Each item is decided in the cycle it is
// accepted; its results (none, one or two) go into a four-entry result queue and
// appear on the output in order, one per cycle while the output is not stalled, the
// first no earlier than the cycle after the transfer. The input is stalled while
// more than two results wait in the queue, so the sustained rate is one item per
// cycle as long as results leave one per cycle and most items yield at most one
// result; the first item of a text yields two when it is a finish or a newline
// or triggers an overflow break. There is no clearing pass after reset.
module word_wrap_break_finder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wwbf_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [wwbf_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [wwbf_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready,
    // character input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_cmd,
    input  logic [wwbf_pkg::CHAR_BITS-1:0]     i_char_code,
    input  logic                               i_glyph_supported,
    input  logic [wwbf_pkg::GLYPH_BITS-1:0]    i_glyph_width,
    // line start output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [wwbf_pkg::POS_BITS-1:0]      o_line_start,
    output logic                               o_is_end,
    output logic                               o_last_of_run
);
    import wwbf_pkg::*;

    t_cfg  cfg;
    t_push push;
    t_res  head;
    logic  in_xfer;
    logic  out_xfer;
    logic  room;

    assign o_in_stall = ~room;
    assign in_xfer    = i_in_valid & room;
    assign out_xfer   = o_out_valid & ~i_out_stall;

    wwbf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    wwbf_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_accept          (in_xfer),
        .i_cmd             (i_cmd),
        .i_char_code       (i_char_code),
        .i_glyph_supported (i_glyph_supported),
        .i_glyph_width     (i_glyph_width),
        .o_push            (push)
    );

    wwbf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_xfer),
        .o_valid (o_out_valid),
        .o_room  (room),
        .o_head  (head)
    );

    assign o_line_start  = head.line_start;
    assign o_is_end      = head.is_end;
    assign o_last_of_run = head.last;

endmodule
